[src/coin_bill_credit_to_pulse_unit_defines.svh]
// Assertion macros used by the top-level RTL.
`ifndef COIN_BILL_CREDIT_TO_PULSE_UNIT_DEFINES_SVH
`define COIN_BILL_CREDIT_TO_PULSE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[src/cbcp_pkg.sv]
package cbcp_pkg;

    localparam int unsigned IN_DATA_W  = 88;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 40;
    localparam int unsigned ADDR_W     = 5;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_PULSE_GAP = 3'd0;
    localparam logic [2:0] REG_BILL_A    = 3'd1;
    localparam logic [2:0] REG_BILL_B    = 3'd2;
    localparam logic [2:0] REG_BILL_C    = 3'd3;
    localparam logic [2:0] REG_BILL_D    = 3'd4;

    localparam logic [7:0] RST_PULSE_GAP = 8'd4;
    localparam logic [7:0] RST_BILL_A    = 8'd2;
    localparam logic [7:0] RST_BILL_B    = 8'd4;
    localparam logic [7:0] RST_BILL_C    = 8'd10;
    localparam logic [7:0] RST_BILL_D    = 8'd20;

    typedef enum logic [1:0] {
        OP_COIN = 2'd0,
        OP_BILL = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        BILL_A = 2'd0,
        BILL_B = 2'd1,
        BILL_C = 2'd2,
        BILL_D = 2'd3
    } t_bill_sel;

    typedef struct packed {
        t_op       op;
        logic      coin_credit;
        logic      bill_clear;
        logic      bill_escrow;
        logic      bill_ok;
        t_bill_sel bill_sel;
    } t_cmd;

    typedef struct packed {
        logic [7:0] pulse_gap;
        logic [7:0] bill_a;
        logic [7:0] bill_b;
        logic [7:0] bill_c;
        logic [7:0] bill_d;
    } t_cfg;

    typedef struct packed {
        logic [15:0] bill_credits;
        logic [15:0] coin_credits;
        logic        coin_credited;
        logic        accept_bill;
        logic        pulse;
    } t_res;

    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [7:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {9'd0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

endpackage

[src/coin_bill_credit_to_pulse_unit.sv]
// Path: the front classifies an input transaction into the queue, then the back unit
//   updates counters into the output register that drives the master side.
// Throughput: one transaction a cycle in and one queue entry out unless output stalls.
// Reset: synchronous, active low; registers return to their defaults, pending credits,
//   gap count and bill latch clear, last event reads as none seen.
`include "coin_bill_credit_to_pulse_unit_defines.svh"

module coin_bill_credit_to_pulse_unit
    import cbcp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [7:0] event_counter, [15:8] result_a, [23:16] result_b, [87:24] history
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] kind
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] pulse, [1] accept_bill, [2] coin_credited, [18:3] coin_credits,
    // [34:19] bill_credits, [39:35] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    t_cfg       r_cfg;
    logic       w_cfg_wr;
    logic [2:0] w_reg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_gap <= RST_PULSE_GAP;
            r_cfg.bill_a    <= RST_BILL_A;
            r_cfg.bill_b    <= RST_BILL_B;
            r_cfg.bill_c    <= RST_BILL_C;
            r_cfg.bill_d    <= RST_BILL_D;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_PULSE_GAP: r_cfg.pulse_gap <= pwdata[7:0];
                REG_BILL_A:    r_cfg.bill_a    <= pwdata[7:0];
                REG_BILL_B:    r_cfg.bill_b    <= pwdata[7:0];
                REG_BILL_C:    r_cfg.bill_c    <= pwdata[7:0];
                REG_BILL_D:    r_cfg.bill_d    <= pwdata[7:0];
                default: ;     // addresses past the register list are ignored
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_PULSE_GAP: prdata = {24'd0, r_cfg.pulse_gap};
            REG_BILL_A:    prdata = {24'd0, r_cfg.bill_a};
            REG_BILL_B:    prdata = {24'd0, r_cfg.bill_b};
            REG_BILL_C:    prdata = {24'd0, r_cfg.bill_c};
            REG_BILL_D:    prdata = {24'd0, r_cfg.bill_d};
            default:       prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // Front: classify each transaction, track coin event history
    // ---------------------------------------------------------------
    t_cmd w_f_cmd;
    t_cmd w_q_cmd;
    logic w_in_acc;
    logic w_q_full;
    logic w_q_valid;
    logic w_q_pop;

    // ready depends only on queue space, never on the back unit's state
    assign s_axis_tready = !w_q_full;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    cbcp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_in_acc),
        .i_kind          (s_axis_tuser[1:0]),
        .i_event_counter (s_axis_tdata[7:0]),
        .i_result_a      (s_axis_tdata[15:8]),
        .i_result_b      (s_axis_tdata[23:16]),
        .i_history       (s_axis_tdata[87:24]),
        .o_cmd           (w_f_cmd)
    );

    // ---------------------------------------------------------------
    // Queue between front and back
    // ---------------------------------------------------------------
    cbcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_in_acc),
        .i_cmd   (w_f_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    // ---------------------------------------------------------------
    // Back: credit counters, bill latch, pulse spacing, output register
    // ---------------------------------------------------------------
    t_res w_res;

    cbcp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_q_cmd),
        .o_q_pop   (w_q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_res     (w_res)
    );

    assign m_axis_tdata = {5'd0, w_res.bill_credits, w_res.coin_credits,
                           w_res.coin_credited, w_res.accept_bill, w_res.pulse};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // at most one of the event flags can be set in a result
    `ASSERT_IMPL(a_flags_exclusive, i_clk, i_rst_n, m_axis_tvalid,
        !(w_res.pulse && w_res.accept_bill) && !(w_res.pulse && w_res.coin_credited)
        && !(w_res.accept_bill && w_res.coin_credited))
    // a credited coin leaves at least one coin pulse pending
    `ASSERT_IMPL(a_coin_credit_nonzero, i_clk, i_rst_n,
        m_axis_tvalid && w_res.coin_credited, w_res.coin_credits != 16'd0)
    // a queued command with a free output register shows up next cycle
    `ASSERT_NEXT(a_queue_drains, i_clk, i_rst_n,
        w_q_valid && (!m_axis_tvalid || m_axis_tready), m_axis_tvalid)

endmodule

[src/cbcp_queue.sv]
module cbcp_queue
    import cbcp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    // two-entry command queue between front and back
    t_cmd       r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr ^ i_push;
        n_rptr  = r_rptr ^ i_pop;
        n_count = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

[src/cbcp_front.sv]
module cbcp_front
    import cbcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_event_counter,
    input  logic [7:0]  i_result_a,
    input  logic [7:0]  i_result_b,
    input  logic [63:0] i_history,
    output t_cmd        o_cmd
);

    // coin event tracking lives here: only coin replies touch it
    logic [8:0]  r_last_event, n_last_event;
    logic [63:0] r_prior_window, n_prior_window;
    logic        w_code_ok;
    logic        w_new_event;

    assign w_code_ok   = (i_result_a >= 8'd1) && (i_result_a <= 8'd10);
    assign w_new_event = w_code_ok && ({1'b0, i_event_counter} != r_last_event);

    always_comb begin
        o_cmd             = '0;
        o_cmd.op          = t_op'(i_kind);
        o_cmd.coin_credit = w_new_event && (i_history == r_prior_window)
                            && (i_result_b >= 8'd1) && (i_result_b <= 8'd6)
                            && (i_result_a <= 8'd9);
        o_cmd.bill_clear  = (i_result_b == 8'd0);
        o_cmd.bill_escrow = (i_result_b == 8'd1);
        o_cmd.bill_ok     = 1'b1;
        case (i_result_a) inside
            8'd1, 8'd6: o_cmd.bill_sel = BILL_A;
            8'd2, 8'd7: o_cmd.bill_sel = BILL_B;
            8'd3, 8'd8: o_cmd.bill_sel = BILL_C;
            8'd4, 8'd9: o_cmd.bill_sel = BILL_D;
            default: begin
                o_cmd.bill_sel = BILL_A;
                o_cmd.bill_ok  = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_last_event   = r_last_event;
        n_prior_window = r_prior_window;
        if (i_accept && (t_op'(i_kind) == OP_COIN)) begin
            if (w_new_event) begin
                n_last_event = {1'b0, i_event_counter};
            end
            n_prior_window = {i_history[47:0], i_result_b, i_result_a};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_event   <= 9'h1FF;
            r_prior_window <= 64'd0;
        end else begin
            r_last_event   <= n_last_event;
            r_prior_window <= n_prior_window;
        end
    end

endmodule

[src/cbcp_back.sv]
module cbcp_back
    import cbcp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_q_valid,
    input  t_cmd i_q_cmd,
    output logic o_q_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);

    logic [15:0] r_coin_pending, n_coin_pending;
    logic [15:0] r_bill_pending, n_bill_pending;
    logic        r_bill_latched, n_bill_latched;
    logic [7:0]  r_gap_count, n_gap_count;
    logic        r_out_valid, n_out_valid;
    t_res        r_res, n_res;
    logic [7:0]  w_bill_add;
    logic        w_latched_eff;
    logic        w_fire;

    assign o_q_pop = i_q_valid && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    always_comb begin
        case (i_q_cmd.bill_sel)
            BILL_A:  w_bill_add = i_cfg.bill_a;
            BILL_B:  w_bill_add = i_cfg.bill_b;
            BILL_C:  w_bill_add = i_cfg.bill_c;
            default: w_bill_add = i_cfg.bill_d;
        endcase
    end

    assign w_latched_eff = r_bill_latched && !i_q_cmd.bill_clear;
    assign w_fire        = !w_latched_eff && i_q_cmd.bill_escrow && i_q_cmd.bill_ok;

    always_comb begin
        n_coin_pending = r_coin_pending;
        n_bill_pending = r_bill_pending;
        n_bill_latched = r_bill_latched;
        n_gap_count    = r_gap_count;
        n_res          = '0;
        if (o_q_pop) begin
            case (i_q_cmd.op)
                OP_COIN: begin
                    if (i_q_cmd.coin_credit) begin
                        n_coin_pending    = sat_add16(r_coin_pending, 8'd1);
                        n_res.coin_credited = 1'b1;
                    end
                end
                OP_BILL: begin
                    n_bill_latched = w_latched_eff;
                    if (w_fire) begin
                        n_bill_pending    = sat_add16(r_bill_pending, w_bill_add);
                        n_bill_latched    = 1'b1;
                        n_res.accept_bill = 1'b1;
                    end
                end
                OP_TICK: begin
                    if (r_gap_count != 8'hFF) begin
                        n_gap_count = r_gap_count + 8'd1;
                    end
                    if (r_gap_count >= i_cfg.pulse_gap) begin
                        if (r_bill_pending != 16'd0) begin
                            n_bill_pending = r_bill_pending - 16'd1;
                            n_gap_count    = 8'd1;
                            n_res.pulse    = 1'b1;
                        end else if (r_coin_pending != 16'd0) begin
                            n_coin_pending = r_coin_pending - 16'd1;
                            n_gap_count    = 8'd1;
                            n_res.pulse    = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        n_res.coin_credits = n_coin_pending;
        n_res.bill_credits = n_bill_pending;
        n_out_valid        = o_q_pop || (r_out_valid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coin_pending <= 16'd0;
            r_bill_pending <= 16'd0;
            r_bill_latched <= 1'b0;
            r_gap_count    <= 8'd0;
            r_out_valid    <= 1'b0;
        end else begin
            r_coin_pending <= n_coin_pending;
            r_bill_pending <= n_bill_pending;
            r_bill_latched <= n_bill_latched;
            r_gap_count    <= n_gap_count;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_res <= n_res;
        end
    end

endmodule
